// ----- hdl/bf3_pkg.sv -----
package bf3_pkg;

	// Payload widths of the stream fields
	localparam int PIX_W   = 16;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 9;
	localparam int M_TDATA_W = 40;
	localparam int M_PAD_W   = M_TDATA_W - (PIX_W + ROW_W + COL_W);

	// Configuration port
	localparam int CFG_W  = 13;
	localparam int CFG_AW = 1;
	localparam int FW_W   = 10;
	localparam int FH_W   = 13;

	typedef enum logic [CFG_AW-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam int FRAME_WIDTH_RST  = 512;
	localparam int FRAME_HEIGHT_RST = 256;
	localparam int MIN_DIM          = 3;

	// Window sum and divide by nine: q = (s * DIV9_MUL) >> DIV9_SHIFT
	// is exact for every s below 2**21, and the rounded sum stays below 2**20.
	localparam int SUM_W      = 20;
	localparam int COLSUM_W   = 18;
	localparam int DIV9_MUL_W = 21;
	localparam int DIV9_SHIFT = 24;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 21'd1864136;
	localparam logic [SUM_W-1:0] ROUND_HALF = 20'd4;

	// Result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Per-item tag that travels with a request through the window pipeline
	typedef struct packed {
		logic             emit;
		logic             interior;
		logic             last;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} tag_t;

	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} out_t;

	function automatic logic [31:0] clamp_dim(input logic [31:0] v, input logic [31:0] hi);
		logic [31:0] r;
		r = v;
		if (v < 32'(MIN_DIM)) begin
			r = 32'(MIN_DIM);
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

// ----- hdl/bf3_ram.sv -----
module bf3_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/bf3_seq.sv -----
module bf3_seq #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bf3_pkg::CFG_AW-1:0]   cfg_addr,
	input  logic [bf3_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         acc,
	input  logic                         action,
	input  logic [bf3_pkg::PIX_W-1:0]    pixel,
	output logic                         step,
	output logic [bf3_pkg::PIX_W-1:0]    value,
	output logic [$clog2(MAX_WIDTH)-1:0] addr,
	output bf3_pkg::tag_t                tag
);

	import bf3_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int IRW = $clog2(MAX_HEIGHT + 2);
	localparam int ERW = $clog2(MAX_HEIGHT);

	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [CW-1:0]  in_col_q;
	logic [IRW-1:0] in_row_q;
	logic [CW-1:0]  ec_q;
	logic [ERW-1:0] er_q;

	logic          past_end;
	logic          emit;
	logic          in_wrap;
	logic          em_wrap;
	logic          last;
	logic          interior;
	logic [CW-1:0] w_last;
	logic [ERW-1:0] h_last;
	cfg_reg_t      reg_sel;

	assign reg_sel = cfg_reg_t'(cfg_addr);
	assign w_last  = CW'(w_q - WW'(1));
	assign h_last  = ERW'(h_q - HW'(1));

	// Classify the request against the current input and output positions
	always_comb begin
		past_end = in_row_q >= IRW'(h_q);
		step     = acc && (past_end || !action);
		value    = past_end ? '0 : pixel;
		emit     = (in_row_q >= IRW'(2)) || ((in_row_q == IRW'(1)) && (in_col_q != '0));
		in_wrap  = (in_col_q == w_last);
		em_wrap  = (ec_q == w_last);
		last     = (er_q == h_last) && em_wrap;
		interior = (er_q != '0) && (er_q < h_last) && (ec_q != '0) && (ec_q < w_last);
	end

	assign addr         = in_col_q;
	assign tag.emit     = emit;
	assign tag.interior = interior;
	assign tag.last     = last;
	assign tag.row      = ROW_W'(32'(er_q));
	assign tag.col      = COL_W'(32'(ec_q));

	// Registers and frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= WW'(clamp_dim(32'(FRAME_WIDTH_RST), 32'(MAX_WIDTH)));
			h_q      <= HW'(clamp_dim(32'(FRAME_HEIGHT_RST), 32'(MAX_HEIGHT)));
			in_col_q <= '0;
			in_row_q <= '0;
			ec_q     <= '0;
			er_q     <= '0;
		end else if (cfg_wr_en) begin
			case (reg_sel)
				REG_FRAME_WIDTH: begin
					w_q <= WW'(clamp_dim(32'(cfg_wdata[FW_W-1:0]), 32'(MAX_WIDTH)));
				end
				REG_FRAME_HEIGHT: begin
					h_q <= HW'(clamp_dim(32'(cfg_wdata[FH_W-1:0]), 32'(MAX_HEIGHT)));
				end
				default: begin
				end
			endcase
			// any write restarts the frame
			in_col_q <= '0;
			in_row_q <= '0;
			ec_q     <= '0;
			er_q     <= '0;
		end else if (step) begin
			if (in_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + IRW'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
			if (emit) begin
				if (last) begin
					in_col_q <= '0;
					in_row_q <= '0;
					ec_q     <= '0;
					er_q     <= '0;
				end else if (em_wrap) begin
					ec_q <= '0;
					er_q <= er_q + ERW'(1);
				end else begin
					ec_q <= ec_q + CW'(1);
				end
			end
		end
	end

endmodule

// ----- hdl/bf3_win.sv -----
module bf3_win #(
	parameter int AW = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  bf3_pkg::tag_t               tag,
	input  logic [bf3_pkg::PIX_W-1:0]   value,
	input  logic [AW-1:0]               addr,
	input  logic [2*bf3_pkg::PIX_W-1:0] rd_data,
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [2*bf3_pkg::PIX_W-1:0] wr_data,
	output logic                        res_valid,
	output bf3_pkg::out_t               res,
	output logic [1:0]                  pend
);

	import bf3_pkg::*;

	localparam int PROD_W = SUM_W + DIV9_MUL_W;

	// Stage 1: line store data arrives
	logic             v_s1;
	tag_t             tag_s1;
	logic [PIX_W-1:0] value_s1;
	logic [AW-1:0]    addr_s1;
	// Stage 2: window sum
	logic             v_s2;
	tag_t             tag_s2;
	// Stage 3: divide and select
	logic             v_s3;
	tag_t             tag_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [PIX_W-1:0] center_s3;

	// Window state: column sums and the middle-row taps
	logic [COLSUM_W-1:0] cs0_q;
	logic [COLSUM_W-1:0] cs1_q;
	logic [COLSUM_W-1:0] cs2_q;
	logic [PIX_W-1:0]    mid1_q;
	logic [PIX_W-1:0]    mid2_q;

	logic [PIX_W-1:0]    up;
	logic [PIX_W-1:0]    lo;
	logic [COLSUM_W-1:0] new_cs;
	logic [PROD_W-1:0]   prod;
	logic [PIX_W-1:0]    quo;

	assign up     = rd_data[2*PIX_W-1:PIX_W];
	assign lo     = rd_data[PIX_W-1:0];
	assign new_cs = COLSUM_W'(up) + COLSUM_W'(lo) + COLSUM_W'(value_s1);

	// Write back the shifted column; within a frame the same entry is read again
	// only a full row later, and the stale read right after a frame's last request
	// only feeds taps above the new frame, so no forwarding is needed
	assign wr_en   = v_s1;
	assign wr_addr = addr_s1;
	assign wr_data = {lo, value_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= step;
			v_s2 <= v_s1 && tag_s1.emit;
			v_s3 <= v_s2;
		end
	end

	// Hold the request payload along the pipe
	always_ff @(posedge clk) begin
		tag_s1    <= tag;
		value_s1  <= value;
		addr_s1   <= addr;
		tag_s2    <= tag_s1;
		tag_s3    <= tag_s2;
		sum_s3    <= SUM_W'(cs0_q) + SUM_W'(cs1_q) + SUM_W'(cs2_q) + ROUND_HALF;
		center_s3 <= mid1_q;
	end

	// Advance the window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs0_q  <= '0;
			cs1_q  <= '0;
			cs2_q  <= '0;
			mid1_q <= '0;
			mid2_q <= '0;
		end else if (v_s1) begin
			cs0_q  <= cs1_q;
			cs1_q  <= cs2_q;
			cs2_q  <= new_cs;
			mid1_q <= mid2_q;
			mid2_q <= lo;
		end
	end

	// Divide by nine through the reciprocal, copy the center on the border
	assign prod = PROD_W'(sum_s3) * PROD_W'(DIV9_MUL);
	assign quo  = prod[DIV9_SHIFT +: PIX_W];

	assign res_valid = v_s3;
	assign res.value = tag_s3.interior ? quo : center_s3;
	assign res.row   = tag_s3.row;
	assign res.col   = tag_s3.col;
	assign res.last  = tag_s3.last;

	assign pend = 2'(v_s1 && tag_s1.emit) + 2'(v_s2) + 2'(v_s3);

endmodule

// ----- hdl/bf3_fifo.sv -----
module bf3_fifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  bf3_pkg::out_t                din,
	input  logic                         pop,
	output bf3_pkg::out_t                dout,
	output logic                         valid,
	output logic [bf3_pkg::FIFO_CW-1:0]  count
);

	import bf3_pkg::*;

	out_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q;
	logic [FIFO_PW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign dout   = mem_q[rd_ptr_q];
	assign valid  = (cnt_q != '0);
	assign count  = cnt_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(do_pop);
		end
	end

endmodule

// ----- hdl/box_filter_3x3_border_copy.sv -----
// The request that completes a result's window arrives one row plus one pixel after its pixel;
// once accepted, the result passes the line read, sum and divide stages into the queue.
// Throughput: one request per cycle, set by the single read/write pass per pixel over the
// combined two-row line memory; s_tready drops while the 8-entry result queue lacks room.
// Reset (arst_n low): counters cleared, window taps zero, frame 512 x 256 (clamped to limits);
// line memory contents are not cleared; unwritten entries it reads reach no interior result.
module box_filter_3x3_border_copy #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bf3_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [bf3_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bf3_pkg::PIX_W-1:0]       s_tdata,  // [15:0] pixel_value
	input  logic                            s_tuser,  // [0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bf3_pkg::M_TDATA_W-1:0]   m_tdata,  // [15:0] filtered_value, [27:16] out_row,
	                                                  // [36:28] out_col, [39:37] zero
	output logic                            m_tlast   // frame_end
);

	import bf3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	logic               acc;
	logic               step;
	logic [PIX_W-1:0]   value;
	logic [AW-1:0]      addr;
	tag_t               tag;
	logic [2*PIX_W-1:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [2*PIX_W-1:0] wr_data;
	logic               res_valid;
	out_t               res;
	logic [1:0]         pend;
	out_t               head;
	logic [FIFO_CW-1:0] q_count;

	// Take a request only while the queue has room for everything in flight
	assign s_tready = ({1'b0, q_count} + (FIFO_CW + 1)'(pend)) < (FIFO_CW + 1)'(FIFO_DEPTH);
	assign acc      = s_tvalid && s_tready;

	bf3_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.action    (s_tuser),
		.pixel     (s_tdata),
		.step      (step),
		.value     (value),
		.addr      (addr),
		.tag       (tag)
	);

	// Two previous rows per column: upper in the high half, lower in the low half
	bf3_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (step),
		.raddr (addr),
		.rdata (rd_data)
	);

	bf3_win #(
		.AW (AW)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.tag       (tag),
		.value     (value),
		.addr      (addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.res_valid (res_valid),
		.res       (res),
		.pend      (pend)
	);

	bf3_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.din    (res),
		.pop    (m_tready),
		.dout   (head),
		.valid  (m_tvalid),
		.count  (q_count)
	);

	assign m_tdata = {M_PAD_W'(0), head.col, head.row, head.value};
	assign m_tlast = head.last;

endmodule

// ----- sim/bf3_tb_pkg.sv -----
`timescale 1ns / 1ps
package bf3_tb_pkg;

	// Request kind carried in tuser
	typedef enum logic {
		ACT_PUSH  = 1'b0,
		ACT_DRAIN = 1'b1
	} action_t;

	// Frame limits of the block as instantiated
	localparam int unsigned FRAME_W_MAX = 512;
	localparam int unsigned FRAME_H_MAX = 4096;

	// Frame dimension that a register value stands for
	function automatic int unsigned usable_dim(input int unsigned v, input int unsigned hi);
		if (v < bf3_pkg::MIN_DIM) begin
			return bf3_pkg::MIN_DIM;
		end
		if (v > hi) begin
			return hi;
		end
		return v;
	endfunction

endpackage

// ----- sim/bf3_window_checker.sv -----
`timescale 1ns / 1ps
module bf3_window_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bf3_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [bf3_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [bf3_pkg::PIX_W-1:0]     s_tdata,  // [15:0] pixel_value
	input  logic                          s_tuser,  // [0] action
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [bf3_pkg::M_TDATA_W-1:0] m_tdata,  // [15:0] filtered_value, [27:16] out_row,
	                                                // [36:28] out_col, [39:37] zero
	input  logic                          m_tlast,  // frame_end
	output int unsigned                   fail_count,
	output int unsigned                   pending
);

	import bf3_pkg::*;
	import bf3_tb_pkg::*;

	// Own copy of the block's registers and window state
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	logic [PIX_W-1:0] two_rows_back [FRAME_W_MAX];
	logic [PIX_W-1:0] one_row_back [FRAME_W_MAX];
	logic [PIX_W-1:0] taps [3][3];
	int unsigned      in_row;
	int unsigned      in_col;
	int unsigned      emit_row;
	int unsigned      emit_col;
	int unsigned      errs;

	// Results predicted but not yet seen on the output
	out_t             filtered_due [$];

	task automatic restart_frame();
		in_row   = 0;
		in_col   = 0;
		emit_row = 0;
		emit_col = 0;
	endtask

	task automatic clear_model();
		int i;
		int j;
		for (i = 0; i < FRAME_W_MAX; i++) begin
			two_rows_back[i] = '0;
			one_row_back[i]  = '0;
		end
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++) begin
				taps[i][j] = '0;
			end
		end
		restart_frame();
		width_reg  = FW_W'(FRAME_WIDTH_RST);
		height_reg = FH_W'(FRAME_HEIGHT_RST);
	endtask

	// Any register write restarts the frame
	task automatic take_register(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
		case (cfg_reg_t'(idx))
			REG_FRAME_WIDTH: begin
				width_reg = val[FW_W-1:0];
				restart_frame();
			end
			REG_FRAME_HEIGHT: begin
				height_reg = val[FH_W-1:0];
				restart_frame();
			end
			default: begin
			end
		endcase
	endtask

	// Shift one request through the line stores and window, predict its result
	task automatic slide_window(input action_t act, input logic [PIX_W-1:0] pix);
		int unsigned      w;
		int unsigned      h;
		int unsigned      col;
		int unsigned      sum;
		int               r;
		int               q;
		logic [PIX_W-1:0] value;
		logic             emit;
		out_t             res;
		w = usable_dim(width_reg, FRAME_W_MAX);
		h = usable_dim(height_reg, FRAME_H_MAX);
		if (in_row < h) begin
			// ignore a drain tick while the frame is still coming in
			if (act == ACT_DRAIN) begin
				return;
			end
			value = pix;
		end else begin
			// past the last pixel every request flushes a zero
			value = '0;
		end
		col = (in_col >= FRAME_W_MAX) ? FRAME_W_MAX - 1 : in_col;
		for (r = 0; r < 3; r++) begin
			taps[r][0] = taps[r][1];
			taps[r][1] = taps[r][2];
		end
		taps[0][2] = two_rows_back[col];
		taps[1][2] = one_row_back[col];
		taps[2][2] = value;
		two_rows_back[col] = one_row_back[col];
		one_row_back[col]  = value;

		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit) begin
			return;
		end

		res.row  = ROW_W'(emit_row);
		res.col  = COL_W'(emit_col);
		res.last = (emit_row == h - 1) && (emit_col == w - 1);
		if (emit_row >= 1 && emit_row <= h - 2 && emit_col >= 1 && emit_col <= w - 2) begin
			// rounded mean of the nine taps
			sum = 0;
			for (r = 0; r < 3; r++) begin
				for (q = 0; q < 3; q++) begin
					sum += taps[r][q];
				end
			end
			res.value = PIX_W'((sum + 4) / 9);
		end else begin
			// border: pass the center tap through
			res.value = taps[1][1];
		end
		filtered_due.push_back(res);

		if (res.last) begin
			restart_frame();
		end else begin
			emit_col++;
			if (emit_col >= w) begin
				emit_col = 0;
				emit_row++;
			end
		end
	endtask

	// Match one output request against the oldest prediction
	task automatic compare_result();
		out_t             due;
		logic [PIX_W-1:0] got_value;
		logic [ROW_W-1:0] got_row;
		logic [COL_W-1:0] got_col;
		got_value = m_tdata[PIX_W-1:0];
		got_row   = m_tdata[PIX_W +: ROW_W];
		got_col   = m_tdata[PIX_W+ROW_W +: COL_W];
		if (filtered_due.size() == 0) begin
			$error("unpredicted result: row %0d col %0d filtered_value %0d",
				got_row, got_col, got_value);
			errs++;
			return;
		end
		due = filtered_due.pop_front();
		if (got_value !== due.value) begin
			$error("filtered_value: expected %0d, actual %0d", due.value, got_value);
			errs++;
		end
		if (got_row !== due.row) begin
			$error("out_row: expected %0d, actual %0d", due.row, got_row);
			errs++;
		end
		if (got_col !== due.col) begin
			$error("out_col: expected %0d, actual %0d", due.col, got_col);
			errs++;
		end
		if (m_tlast !== due.last) begin
			$error("frame_end: expected %0d, actual %0d", due.last, m_tlast);
			errs++;
		end
	endtask

	// Watch the config port and both stream channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			filtered_due.delete();
			errs = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				take_register(cfg_addr, cfg_wdata);
			end
			if (s_tvalid && s_tready) begin
				slide_window(action_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) begin
				compare_result();
			end
			fail_count <= errs;
			pending    <= filtered_due.size();
		end
	end

endmodule

// ----- sim/tb_box_filter_3x3_border_copy.sv -----
`timescale 1ns / 1ps
module tb_box_filter_3x3_border_copy;

	import bf3_pkg::*;
	import bf3_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 16;
	localparam int RANDOM_ITEMS   = 350;
	localparam int WIDE_PIXELS    = 530;
	localparam int TALL_PIXELS    = 40;

	typedef enum {PIX_NOISE, PIX_FULL_SCALE, PIX_LOW, PIX_RAILS} pix_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_AW-1:0]      cfg_addr = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [PIX_W-1:0]       s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;

	int unsigned            fail_count;
	int unsigned            pending;
	int unsigned            idle_cycles = 0;
	logic [5:0]             stall_phase = '0;
	logic [15:0]            stall_mask = 16'hFFFF;

	int                     burst_left = 0;
	bit                     steady = 1'b0;
	int                     eff_w = FRAME_WIDTH_RST;
	int                     eff_h = FRAME_HEIGHT_RST;
	int                     items_sent = 0;

	box_filter_3x3_border_copy dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	bf3_window_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Stall the output on a 16-bit mask that is redrawn each time stall_phase wraps
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		if (stall_phase == '0) begin
			stall_mask <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
		end
		m_tready <= stall_mask[stall_phase[3:0]];
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_box_filter_3x3_border_copy: errors");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] pixel_for(input pix_style_t style);
		case (style)
			PIX_FULL_SCALE: return '1;
			PIX_LOW:        return PIX_W'($urandom_range(0, 3));
			PIX_RAILS:      return $urandom_range(0, 1) ? '1 : '0;
			default:        return PIX_W'($urandom);
		endcase
	endfunction

	// Offer one request, with a random gap at the start of each burst
	task automatic send_item(input action_t act, input logic [PIX_W-1:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= pix;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Hold off the input until every predicted result has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Write frame registers with the block idle
	task automatic set_frame(input bit do_w, input logic [CFG_W-1:0] w_raw,
			input bit do_h, input logic [CFG_W-1:0] h_raw);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (do_w) begin
			cfg_wr_en <= 1'b1;
			cfg_addr  <= REG_FRAME_WIDTH;
			cfg_wdata <= w_raw;
			@(posedge clk);
			eff_w = usable_dim(w_raw[FW_W-1:0], FRAME_W_MAX);
		end
		if (do_h) begin
			cfg_wr_en <= 1'b1;
			cfg_addr  <= REG_FRAME_HEIGHT;
			cfg_wdata <= h_raw;
			@(posedge clk);
			eff_h = usable_dim(h_raw[FH_W-1:0], FRAME_H_MAX);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Push a frame (or its first abort_at pixels); after a full frame, flush the pending results
	task automatic run_frame(input pix_style_t style, input int abort_at);
		int npix;
		int pause_at;
		int i;
		npix = (abort_at >= 0) ? abort_at : eff_w * eff_h;
		pause_at = ($urandom_range(0, 2) == 0 && npix > 0) ? $urandom_range(0, npix - 1) : -1;
		for (i = 0; i < npix; i++) begin
			// stray drain tick while the frame is incomplete
			if ($urandom_range(0, 15) == 0) begin
				send_item(ACT_DRAIN, PIX_W'($urandom));
			end
			if (i == pause_at) begin
				drain_results();
			end
			send_item(ACT_PUSH, pixel_for(style));
			items_sent++;
		end
		if (abort_at < 0) begin
			// flush; a push here is dropped and acts as a drain
			for (i = 0; i <= eff_w; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_item(ACT_PUSH, PIX_W'($urandom));
				end else begin
					send_item(ACT_DRAIN, PIX_W'($urandom));
				end
				items_sent++;
			end
			repeat ($urandom_range(0, 2)) send_item(ACT_DRAIN, PIX_W'($urandom));
		end
	endtask

	initial begin
		int  i;
		int  wv;
		int  hv;
		int  pick;
		int  abort_at;
		bit  need_restart;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// drain with nothing pushed, then a few pixels at the reset frame size
		send_item(ACT_DRAIN, '1);
		for (i = 0; i < 3; i++) begin
			send_item(ACT_PUSH, PIX_W'($urandom));
		end

		// 3x3 frame from out-of-range values, full-scale pixels
		set_frame(1'b1, 13'h1C00, 1'b1, 13'd1);
		for (i = 0; i < 9; i++) begin
			if (i == 4) begin
				send_item(ACT_DRAIN, '0);
			end
			if (i == 6) begin
				drain_results();
			end
			send_item(ACT_PUSH, '1);
		end
		send_item(ACT_DRAIN, '1);
		send_item(ACT_PUSH, 16'h5A5A);
		send_item(ACT_DRAIN, '0);
		send_item(ACT_DRAIN, '0);
		send_item(ACT_DRAIN, '0);

		// random frames, mostly small
		need_restart = 1'b0;
		while (items_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			wv = (pick == 0) ? $urandom_range(0, 2) :
				(pick < 3) ? $urandom_range(13, 40) : $urandom_range(3, 12);
			pick = $urandom_range(0, 9);
			hv = (pick == 0) ? $urandom_range(0, 2) :
				(pick < 3) ? $urandom_range(9, 16) : $urandom_range(3, 8);
			pick = $urandom_range(need_restart ? 1 : 0, 3);
			if (pick != 0) begin
				set_frame(pick != 2, {3'($urandom), 10'(wv)}, pick != 1, 13'(hv));
			end
			abort_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, eff_w * eff_h - 1) : -1;
			need_restart = (abort_at >= 0);
			run_frame(pix_style_t'($urandom_range(0, 3)), abort_at);
		end

		// start of the widest frame past its first row, then of the tallest frame
		steady = 1'b0;
		set_frame(1'b1, 13'h1FFF, 1'b1, 13'd3);
		run_frame(PIX_NOISE, WIDE_PIXELS);
		set_frame(1'b1, 13'd3, 1'b1, 13'h1FFF);
		run_frame(PIX_RAILS, TALL_PIXELS);

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_box_filter_3x3_border_copy: clean");
		end else begin
			$display("tb_box_filter_3x3_border_copy: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/bf3_pkg.sv
hdl/bf3_ram.sv
hdl/bf3_seq.sv
hdl/bf3_win.sv
hdl/bf3_fifo.sv
hdl/box_filter_3x3_border_copy.sv
sim/bf3_tb_pkg.sv
sim/bf3_window_checker.sv
sim/tb_box_filter_3x3_border_copy.sv
